// ----- rtl/bracket_ident_number_lexer_macros.svh -----
// ----------------------------------------------------------------------------
// bracket_ident_number_lexer_macros.svh
// assertion macros shared by the lexer modules
// ----------------------------------------------------------------------------
`ifndef BRACKET_IDENT_NUMBER_LEXER_MACROS_SVH
`define BRACKET_IDENT_NUMBER_LEXER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked on every clock edge out of reset
`define BIL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BIL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BIL_ASSERT_IMPL(label, ante, cons, msg)
`define BIL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/bil_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_pkg
// types, character codes and helper functions of the bracket lexer
// ----------------------------------------------------------------------------
package bil_pkg;

   // position and length counter width, saturating
   localparam int COUNT_WIDTH = 16;
   localparam int OUT_WIDTH   = 16;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   // token queue depth
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   // character codes
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_D = 8'h64;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_DOT,
      MODE_FLOAT
   } mode_type;

   typedef enum logic [3:0] {
      KIND_LBRACK = 4'd0,
      KIND_RBRACK = 4'd1,
      KIND_LPAREN = 4'd2,
      KIND_RPAREN = 4'd3,
      KIND_LBRACE = 4'd4,
      KIND_RBRACE = 4'd5,
      KIND_FN     = 4'd6,
      KIND_DF     = 4'd7,
      KIND_IDENT  = 4'd8,
      KIND_INT    = 4'd9,
      KIND_FLOAT  = 4'd10
   } token_kind_type;

   typedef struct packed {
      token_kind_type         kind;
      logic [OUT_WIDTH-1:0]   length;
      logic [OUT_WIDTH-1:0]   column;
      logic [OUT_WIDTH-1:0]   row;
      logic                   last;
   } token_type;

   // tokens produced by one item, in order
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_ident_char(logic [7:0] c);
      logic alpha;
      logic sym;
      alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
      sym = (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_EQUAL) || (c == CH_UNDER) ||
            (c == CH_BANG) || (c == CH_AT) || (c == CH_HASH) || (c == CH_DOLLAR) ||
            (c == CH_PERCENT) || (c == CH_CARET) || (c == CH_AMP) || (c == CH_STAR) ||
            (c == CH_SLASH) || (c == CH_TILDE);
      return is_digit(c) || alpha || sym;
   endfunction

   function automatic logic is_bracket(logic [7:0] c);
      return (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LPAREN) ||
             (c == CH_RPAREN) || (c == CH_LBRACE) || (c == CH_RBRACE);
   endfunction

   function automatic token_kind_type bracket_kind(logic [7:0] c);
      token_kind_type k;
      case (c)
         CH_LBRACK: k = KIND_LBRACK;
         CH_RBRACK: k = KIND_RBRACK;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_LBRACE: k = KIND_LBRACE;
         default:   k = KIND_RBRACE;
      endcase
      return k;
   endfunction

   // kind of the token being flushed from a scan mode
   function automatic token_kind_type flush_kind(mode_type m, logic [COUNT_WIDTH-1:0] len,
                                                 logic [7:0] fb, logic [7:0] sb);
      token_kind_type k;
      case (m)
         MODE_IDENT: begin
            k = KIND_IDENT;
            if (len == COUNT_WIDTH'(2)) begin
               if ((fb == CH_LOWER_F) && (sb == CH_LOWER_N)) begin
                  k = KIND_FN;
               end else if ((fb == CH_LOWER_D) && (sb == CH_LOWER_F)) begin
                  k = KIND_DF;
               end
            end
         end
         MODE_INT:   k = KIND_INT;
         MODE_DOT:   k = KIND_INT;
         MODE_FLOAT: k = KIND_FLOAT;
         default:    k = KIND_IDENT;
      endcase
      return k;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
      return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_add2(logic [COUNT_WIDTH-1:0] v);
      return (v >= CNT_MAX - COUNT_WIDTH'(1)) ? CNT_MAX : v + COUNT_WIDTH'(2);
   endfunction

   // clamp a counter to the output field width
   function automatic logic [OUT_WIDTH-1:0] clamp_out(logic [COUNT_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? '1 : w[OUT_WIDTH-1:0];
   endfunction

endpackage

// ----- rtl/bil_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_ifs
// valid/ready channel interfaces for source bytes and tokens
// ----------------------------------------------------------------------------

// source byte channel
interface bil_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       end_of_source;

   modport source (output valid, output character, output end_of_source, input ready);
   modport sink   (input valid, input character, input end_of_source, output ready);
endinterface

// token channel
interface bil_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] token_length;
   logic [15:0] start_column;
   logic [15:0] start_row;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_length,
                   output start_column, output start_row, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_length,
                   input start_column, input start_row, input last_of_run,
                   output ready);
endinterface

// ----- rtl/bracket_ident_number_lexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_ident_number_lexer
// byte-serial lexer for brackets, identifiers, keywords, integers and floats
// ----------------------------------------------------------------------------
// Takes one source byte per item on req_if and delivers tokens on rsp_if,
// each with kind, saturating length, and start column and row. A token
// appears once the byte after it arrives, or at end of source; a bracket
// token comes with its own byte. Bytes are accepted one per cycle; an item
// waits in the input register until the token queue has room, and then its
// tokens go in. The output port delivers one token per cycle while rsp_if is
// ready; for a byte that gives two tokens (a token ended by a bracket, or a
// token ended on the final byte by one that starts another) the four-entry
// token queue absorbs the extra token. It takes in bytes only while it has
// room for two tokens, so input stalls only when tokens pile up faster than
// rsp_if drains them. last_of_run marks the final token of each byte.
// ----------------------------------------------------------------------------

module bracket_ident_number_lexer (
   input  logic      clock,
   input  logic      reset,
   bil_req_if.sink   req_if,
   bil_rsp_if.source rsp_if
);

   bil_pkg::push_type push;
   logic              room;

   // scan state and token generation
   bil_scan_core u_scan_core (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .room   (room),
      .push   (push)
   );

   // token queue and result port
   bil_token_fifo u_token_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_if (rsp_if)
   );

endmodule

// ----- rtl/bil_scan_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_scan_core
// input register, scan state and token generation for one byte per cycle while the token queue has room
// ----------------------------------------------------------------------------
`include "bracket_ident_number_lexer_macros.svh"

module bil_scan_core (
   input  logic                clock,
   input  logic                reset,
   bil_req_if.sink             req_if,
   input  logic                room,
   output bil_pkg::push_type   push
);

   localparam int CW = bil_pkg::COUNT_WIDTH;

   // input register
   logic       in_valid_ff;
   logic [7:0] char_ff;
   logic       eos_ff;
   logic       consume;

   // scan state
   bil_pkg::mode_type mode_ff, mode_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [CW-1:0]     pcol_ff, pcol_in;
   logic [CW-1:0]     prow_ff, prow_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [CW-1:0]     row_ff, row_in;
   logic [7:0]        fb_ff, fb_in;
   logic [7:0]        sb_ff, sb_in;

   // state after the byte, before end of source handling
   bil_pkg::mode_type mid_mode;
   logic [CW-1:0]     mid_len, mid_pcol, mid_prow, cur_col, cur_row;
   logic [7:0]        mid_fb, mid_sb;
   logic              used;
   logic              digit, ident, brk;

   // scanner sits at the reset position
   logic              at_home;

   assign consume      = in_valid_ff && room;
   assign req_if.ready = !in_valid_ff || room;

   // input register, holds while the token queue lacks room for two tokens
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.valid && req_if.ready) begin
         char_ff <= req_if.character;
         eos_ff  <= req_if.end_of_source;
      end
   end

   assign digit = bil_pkg::is_digit(char_ff);
   assign ident = bil_pkg::is_ident_char(char_ff);
   assign brk   = bil_pkg::is_bracket(char_ff);

   // next state
   always_comb begin
      if (char_ff == bil_pkg::CH_NEWLINE) begin
         cur_col = '0;
         cur_row = bil_pkg::sat_inc(row_ff);
      end else begin
         cur_col = bil_pkg::sat_inc(col_ff);
         cur_row = row_ff;
      end

      used     = 1'b0;
      mid_mode = mode_ff;
      mid_len  = len_ff;
      mid_pcol = pcol_ff;
      mid_prow = prow_ff;
      mid_fb   = fb_ff;
      mid_sb   = sb_ff;

      // extend the pending token
      case (mode_ff)
         bil_pkg::MODE_IDENT: begin
            if (ident) begin
               used = 1'b1;
               if (len_ff == CW'(1)) begin
                  mid_sb = char_ff;
               end
               mid_len = bil_pkg::sat_inc(len_ff);
            end
         end
         bil_pkg::MODE_INT: begin
            if (digit) begin
               used    = 1'b1;
               mid_len = bil_pkg::sat_inc(len_ff);
            end else if (char_ff == bil_pkg::CH_DOT) begin
               used     = 1'b1;
               mid_mode = bil_pkg::MODE_DOT;
            end
         end
         bil_pkg::MODE_DOT: begin
            if (digit) begin
               used     = 1'b1;
               mid_len  = bil_pkg::sat_add2(len_ff);
               mid_mode = bil_pkg::MODE_FLOAT;
            end
         end
         bil_pkg::MODE_FLOAT: begin
            if (digit) begin
               used    = 1'b1;
               mid_len = bil_pkg::sat_inc(len_ff);
            end
         end
         default: begin
            mid_mode = bil_pkg::MODE_IDLE;
         end
      endcase

      // byte not taken: pending token flushed, maybe a new one starts
      if (!used) begin
         mid_mode = bil_pkg::MODE_IDLE;
         if (!brk && ident) begin
            mid_mode = digit ? bil_pkg::MODE_INT : bil_pkg::MODE_IDENT;
            mid_len  = CW'(1);
            mid_pcol = cur_col;
            mid_prow = cur_row;
            mid_fb   = char_ff;
            mid_sb   = '0;
         end
      end

      // end of source returns everything to reset
      if (eos_ff) begin
         mode_in = bil_pkg::MODE_IDLE;
         len_in  = '0;
         pcol_in = '0;
         prow_in = CW'(1);
         col_in  = '0;
         row_in  = CW'(1);
         fb_in   = '0;
         sb_in   = '0;
      end else begin
         mode_in = mid_mode;
         len_in  = mid_len;
         pcol_in = mid_pcol;
         prow_in = mid_prow;
         col_in  = cur_col;
         row_in  = cur_row;
         fb_in   = mid_fb;
         sb_in   = mid_sb;
      end
   end

   // tokens for this item
   always_comb begin
      bil_pkg::token_type tok_a, tok_b, tok_c;
      logic a_valid, b_valid, c_valid;

      a_valid = consume && !used && (mode_ff != bil_pkg::MODE_IDLE);
      b_valid = consume && !used && brk;
      c_valid = consume && eos_ff && (mid_mode != bil_pkg::MODE_IDLE);

      tok_a.kind   = bil_pkg::flush_kind(mode_ff, len_ff, fb_ff, sb_ff);
      tok_a.length = bil_pkg::clamp_out(len_ff);
      tok_a.column = bil_pkg::clamp_out(pcol_ff);
      tok_a.row    = bil_pkg::clamp_out(prow_ff);
      tok_a.last   = 1'b0;

      tok_b.kind   = bil_pkg::bracket_kind(char_ff);
      tok_b.length = bil_pkg::OUT_WIDTH'(1);
      tok_b.column = bil_pkg::clamp_out(cur_col);
      tok_b.row    = bil_pkg::clamp_out(cur_row);
      tok_b.last   = 1'b0;

      tok_c.kind   = bil_pkg::flush_kind(mid_mode, mid_len, mid_fb, mid_sb);
      tok_c.length = bil_pkg::clamp_out(mid_len);
      tok_c.column = bil_pkg::clamp_out(mid_pcol);
      tok_c.row    = bil_pkg::clamp_out(mid_prow);
      tok_c.last   = 1'b0;

      // a bracket leaves the mode idle, so at most two tokens are valid
      push.count = 2'(a_valid) + 2'(b_valid) + 2'(c_valid);
      if (a_valid) begin
         push.tok0 = tok_a;
         push.tok1 = b_valid ? tok_b : tok_c;
      end else begin
         push.tok0 = b_valid ? tok_b : tok_c;
         push.tok1 = tok_c;
      end
      push.tok0.last = (push.count == 2'd1);
      push.tok1.last = 1'b1;
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bil_pkg::MODE_IDLE;
         len_ff  <= '0;
         pcol_ff <= '0;
         prow_ff <= CW'(1);
         col_ff  <= '0;
         row_ff  <= CW'(1);
         fb_ff   <= '0;
         sb_ff   <= '0;
      end else if (consume) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         pcol_ff <= pcol_in;
         prow_ff <= prow_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         fb_ff   <= fb_in;
         sb_ff   <= sb_in;
      end
   end

   assign at_home = (mode_ff == bil_pkg::MODE_IDLE) && (col_ff == '0) && (row_ff == CW'(1));

   `BIL_ASSERT_NEXT(a_eos_resets, consume && eos_ff, at_home, "no reset after end of source")
   `BIL_ASSERT_IMPL(a_push_room, push.count != 2'd0, room, "tokens pushed without queue room")
   `BIL_ASSERT_IMPL(a_pending_len, mode_ff != bil_pkg::MODE_IDLE, len_ff != '0, "zero length")

endmodule

// ----- rtl/bil_token_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_token_fifo
// small token queue taking up to two tokens per cycle, one out per cycle while rsp_if is ready
// ----------------------------------------------------------------------------
`include "bracket_ident_number_lexer_macros.svh"

module bil_token_fifo (
   input  logic                clock,
   input  logic                reset,
   input  bil_pkg::push_type   push,
   output logic                room,
   bil_rsp_if.source           rsp_if
);

   localparam int PW = bil_pkg::FIFO_PTR_WIDTH;
   localparam int NW = bil_pkg::FIFO_CNT_WIDTH;

   bil_pkg::token_type entry_ff [bil_pkg::FIFO_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]      count_ff, count_in;
   logic               pop;
   logic               idle_pop;
   bil_pkg::token_type head;

   // room for the worst case of two tokens from one item
   assign room = (count_ff <= NW'(bil_pkg::FIFO_DEPTH - 2));
   assign pop  = rsp_if.valid && rsp_if.ready;

   // pop with nothing pushed in the same cycle
   assign idle_pop = (push.count == 2'd0) && pop;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push.count);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + NW'(push.count) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PW'(1)] <= push.tok1;
      end
   end

   // head of queue to the result port
   assign head                = entry_ff[rd_ptr_ff];
   assign rsp_if.valid        = (count_ff != '0);
   assign rsp_if.token_kind   = head.kind;
   assign rsp_if.token_length = head.length;
   assign rsp_if.start_column = head.column;
   assign rsp_if.start_row    = head.row;
   assign rsp_if.last_of_run  = head.last;

   `BIL_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= NW'(bil_pkg::FIFO_DEPTH), "queue overflow")
   `BIL_ASSERT_IMPL(a_push_count, 1'b1, push.count != 2'd3, "more than two tokens from one item")
   `BIL_ASSERT_NEXT(a_pop_drains, idle_pop, count_ff == $past(count_ff) - NW'(1), "no drain")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bracket/identifier/number lexer
// ----------------------------------------------------------------------------
// Source bytes are queued up front and driven one item at a time on req_if
// with random gaps. A predictor follows every accepted byte and keeps the
// tokens it should produce in order. The monitor pulls tokens off rsp_if
// with its own random stalls and compares each field with the oldest
// predicted token. The stimulus runs a short directed source, then random
// token streams with noise and broken numbers, then a short source that
// checks the position starts over after end of source.
// ----------------------------------------------------------------------------

module testbench;

   localparam int          CW           = bil_pkg::COUNT_WIDTH;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned HOLD_AT      = 300;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned RANDOM_ITEMS = 820;

   typedef struct {
      logic [7:0] ch;
      logic       eos;
      bit         burst;
   } src_item_type;

   typedef struct {
      bil_pkg::token_kind_type kind;
      logic [15:0]             length;
      logic [15:0]             column;
      logic [15:0]             row;
      logic                    last;
   } lexed_token_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bil_req_if req_if ();
   bil_rsp_if rsp_if ();

   bracket_ident_number_lexer uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // stimulus and expectations
   src_item_type    source_items[$];
   lexed_token_type expected_tokens[$];
   src_item_type    next_item;
   int unsigned     total_items;

   // predictor state
   bil_pkg::mode_type scan_state;
   logic [CW-1:0]     run_len;
   logic [CW-1:0]     run_col;
   logic [CW-1:0]     run_row;
   logic [CW-1:0]     col_now;
   logic [CW-1:0]     row_now;
   logic [7:0]        lead_char;
   logic [7:0]        next_char;
   lexed_token_type   step_tokens[2];
   int unsigned       step_count;

   // handshake pacing
   int unsigned cycle_count = 0;
   int unsigned send_gap;
   int unsigned take_gap;
   int unsigned hold_left;
   logic        offering;

   // statistics
   int unsigned bytes_accepted = 0;
   int unsigned tokens_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned eos_seen       = 0;
   int unsigned double_steps   = 0;
   int unsigned longest_token  = 0;
   bit          kind_hits[16];

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // saturating counter step
   function automatic logic [CW-1:0] bump(logic [CW-1:0] v, int unsigned step);
      logic [CW:0] sum;
      sum = (CW+1)'(v) + (CW+1)'(step);
      return sum[CW] ? bil_pkg::CNT_MAX : sum[CW-1:0];
   endfunction

   // counters wider than the output field stick at all ones
   function automatic logic [15:0] to_out(logic [CW-1:0] v);
      return (64'(v) > 64'hFFFF) ? 16'hFFFF : 16'(v);
   endfunction

   task automatic clear_lexer();
      scan_state = bil_pkg::MODE_IDLE;
      run_len    = '0;
      run_col    = '0;
      run_row    = CW'(1);
      col_now    = '0;
      row_now    = CW'(1);
      lead_char  = '0;
      next_char  = '0;
   endtask

   task automatic note_token(bil_pkg::token_kind_type kind, logic [CW-1:0] len,
                             logic [CW-1:0] col, logic [CW-1:0] row);
      step_tokens[step_count] = '{kind, to_out(len), to_out(col), to_out(row), 1'b0};
      step_count++;
   endtask

   // emit the token in progress, if any
   task automatic close_run();
      bil_pkg::token_kind_type kind;
      kind = bil_pkg::KIND_IDENT;
      case (scan_state)
         bil_pkg::MODE_IDENT: begin
            if (run_len == CW'(2)) begin
               if (lead_char == bil_pkg::CH_LOWER_F && next_char == bil_pkg::CH_LOWER_N) begin
                  kind = bil_pkg::KIND_FN;
               end else if (lead_char == bil_pkg::CH_LOWER_D &&
                            next_char == bil_pkg::CH_LOWER_F) begin
                  kind = bil_pkg::KIND_DF;
               end
            end
         end
         bil_pkg::MODE_INT, bil_pkg::MODE_DOT: kind = bil_pkg::KIND_INT;
         bil_pkg::MODE_FLOAT: kind = bil_pkg::KIND_FLOAT;
         default: return;
      endcase
      note_token(kind, run_len, run_col, run_row);
      scan_state = bil_pkg::MODE_IDLE;
   endtask

   // one accepted byte: advance the lexer and queue the tokens it gives
   task automatic lex_char(logic [7:0] c, logic eos);
      logic                    is_num;
      logic                    is_word;
      logic                    is_brk;
      logic                    taken;
      bil_pkg::token_kind_type brk_kind;
      is_num   = (c >= "0") && (c <= "9");
      is_word  = is_num || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
      is_brk   = 1'b0;
      brk_kind = bil_pkg::KIND_LBRACK;
      taken    = 1'b0;
      step_count = 0;

      // symbols that may appear in identifiers, and the bracket kinds
      case (c)
         bil_pkg::CH_MINUS, bil_pkg::CH_PLUS, bil_pkg::CH_EQUAL, bil_pkg::CH_UNDER,
         bil_pkg::CH_BANG, bil_pkg::CH_AT, bil_pkg::CH_HASH, bil_pkg::CH_DOLLAR,
         bil_pkg::CH_PERCENT, bil_pkg::CH_CARET, bil_pkg::CH_AMP, bil_pkg::CH_STAR,
         bil_pkg::CH_SLASH, bil_pkg::CH_TILDE: is_word = 1'b1;
         bil_pkg::CH_LBRACK: is_brk = 1'b1;
         bil_pkg::CH_RBRACK: begin
            is_brk = 1'b1;
            brk_kind = bil_pkg::KIND_RBRACK;
         end
         bil_pkg::CH_LPAREN: begin
            is_brk = 1'b1;
            brk_kind = bil_pkg::KIND_LPAREN;
         end
         bil_pkg::CH_RPAREN: begin
            is_brk = 1'b1;
            brk_kind = bil_pkg::KIND_RPAREN;
         end
         bil_pkg::CH_LBRACE: begin
            is_brk = 1'b1;
            brk_kind = bil_pkg::KIND_LBRACE;
         end
         bil_pkg::CH_RBRACE: begin
            is_brk = 1'b1;
            brk_kind = bil_pkg::KIND_RBRACE;
         end
         default: ;
      endcase

      // position of this byte
      if (c == bil_pkg::CH_NEWLINE) begin
         col_now = '0;
         row_now = bump(row_now, 1);
      end else begin
         col_now = bump(col_now, 1);
      end

      // extend the token in progress
      case (scan_state)
         bil_pkg::MODE_IDENT: begin
            if (is_word) begin
               if (run_len == CW'(1)) next_char = c;
               run_len = bump(run_len, 1);
               taken = 1'b1;
            end
         end
         bil_pkg::MODE_INT: begin
            if (is_num) begin
               run_len = bump(run_len, 1);
               taken = 1'b1;
            end else if (c == bil_pkg::CH_DOT) begin
               scan_state = bil_pkg::MODE_DOT;
               taken = 1'b1;
            end
         end
         bil_pkg::MODE_DOT: begin
            // the dot is counted together with the first fraction digit
            if (is_num) begin
               run_len = bump(run_len, 2);
               scan_state = bil_pkg::MODE_FLOAT;
               taken = 1'b1;
            end
         end
         bil_pkg::MODE_FLOAT: begin
            if (is_num) begin
               run_len = bump(run_len, 1);
               taken = 1'b1;
            end
         end
         default: ;
      endcase

      // otherwise close it and take the byte on its own
      if (!taken) begin
         close_run();
         if (is_brk) begin
            note_token(brk_kind, CW'(1), col_now, row_now);
         end else if (is_word) begin
            scan_state = is_num ? bil_pkg::MODE_INT : bil_pkg::MODE_IDENT;
            run_len    = CW'(1);
            run_col    = col_now;
            run_row    = row_now;
            lead_char  = c;
            next_char  = '0;
         end
      end

      // end of source flushes and starts over at the first position
      if (eos) begin
         close_run();
         clear_lexer();
         eos_seen++;
      end

      if (step_count != 0) step_tokens[step_count - 1].last = 1'b1;
      if (step_count == 2) double_steps++;
      for (int i = 0; i < step_count; i++) begin
         expected_tokens.push_back(step_tokens[i]);
         kind_hits[step_tokens[i].kind] = 1'b1;
         if (step_tokens[i].length > longest_token) longest_token = step_tokens[i].length;
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   task automatic add_char(logic [7:0] c, logic eos = 1'b0, bit burst = 1'b0);
      src_item_type it;
      it.ch    = c;
      it.eos   = eos;
      it.burst = burst;
      source_items.push_back(it);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_letter();
      logic [7:0] base;
      base = $urandom_range(1) ? "a" : "A";
      return 8'(base + $urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_symbol();
      string syms;
      syms = "-+=_!@#$%^&*/~";
      return syms[$urandom_range(13)];
   endfunction

   function automatic logic [7:0] rand_bracket();
      string brackets;
      brackets = "[]()}{";
      return brackets[$urandom_range(5)];
   endfunction

   // identifiers never start with a digit
   function automatic logic [7:0] rand_word_start();
      return ($urandom_range(3) == 0) ? rand_symbol() : rand_letter();
   endfunction

   function automatic logic [7:0] rand_word_char();
      int unsigned r;
      r = $urandom_range(5);
      if (r == 0) return rand_digit();
      if (r == 1) return rand_symbol();
      return rand_letter();
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned idle_len(bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // ------------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid         <= 1'b0;
         req_if.character     <= '0;
         req_if.end_of_source <= 1'b0;
         send_gap = 0;
         clear_lexer();
      end else begin
         offering = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            lex_char(req_if.character, req_if.end_of_source);
            bytes_accepted++;
            offering = 1'b0;
            if (source_items.size() != 0 && !source_items[0].burst) begin
               send_gap = idle_len(cycle_count[10:9] == 2'b00);
            end
         end
         if (!offering) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (source_items.size() != 0) begin
               next_item = source_items.pop_front();
               req_if.character     <= next_item.ch;
               req_if.end_of_source <= next_item.eos;
               offering = 1'b1;
            end
         end
         req_if.valid <= offering;
      end
   end

   // ------------------------------------------------------------------------
   // monitor
   // ------------------------------------------------------------------------
   task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      lexed_token_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            tokens_checked++;
            if (expected_tokens.size() == 0) begin
               $error("token_kind: expected no token, got %0d at column %0d row %0d",
                      rsp_if.token_kind, rsp_if.start_column, rsp_if.start_row);
               mismatch_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", 16'(want.kind), 16'(rsp_if.token_kind));
               check_field("token_length", want.length, rsp_if.token_length);
               check_field("start_column", want.column, rsp_if.start_column);
               check_field("start_row", want.row, rsp_if.start_row);
               check_field("last_of_run", 16'(want.last), 16'(rsp_if.last_of_run));
            end
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
         end else if (take_gap != 0) begin
            take_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            take_gap = idle_len(cycle_count[10:9] == 2'b01);
         end
      end
   end

   // long receiver hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (cycle_count == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("no end after %0d cycles, %0d of %0d items taken, %0d tokens outstanding",
                CYCLE_LIMIT, bytes_accepted, total_items, expected_tokens.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int unsigned directed_items;
      int unsigned sources_left;
      int unsigned pick;
      int unsigned kinds_seen;
      string       near_words[7];

      near_words = '{"fn", "df", "fd", "dn", "fnn", "f", "d"};

      // keywords next to parens: token then bracket on one byte
      add_text("fn(df)");
      // float closed by a bracket
      add_text("[1.25]");
      // digits and a dot before a non-digit give an integer
      add_text("7.}");
      // newline, brace, three-letter word that is no keyword
      add_char(bil_pkg::CH_NEWLINE);
      add_text("{fnx");
      // bytes outside ascii and a zero byte are skipped
      add_char(8'hFF);
      add_char(8'h00);
      // dangling dot on the final byte
      add_char("9");
      add_char(bil_pkg::CH_DOT, 1'b1);

      // random token streams with separators, noise and broken numbers
      directed_items = source_items.size();
      sources_left = $urandom_range(30, 0);
      while (source_items.size() < directed_items + RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 18) begin
            add_char(rand_bracket());
         end else if (pick < 26) begin
            add_text(near_words[$urandom_range(6)]);
         end else if (pick < 50) begin
            add_char(rand_word_start());
            repeat ($urandom_range(6)) add_char(rand_word_char());
         end else if (pick < 64) begin
            repeat ($urandom_range(5, 1)) add_char(rand_digit());
         end else if (pick < 76) begin
            repeat ($urandom_range(4, 1)) add_char(rand_digit());
            add_char(bil_pkg::CH_DOT);
            repeat ($urandom_range(4, 1)) add_char(rand_digit());
         end else if (pick < 88) begin
            // stray or trailing dot followed by a non-digit
            repeat ($urandom_range(3)) add_char(rand_digit());
            add_char(bil_pkg::CH_DOT);
            case ($urandom_range(3))
               0: add_char(bil_pkg::CH_DOT);
               1: add_char(rand_word_start());
               2: add_char(rand_bracket());
               default: add_char(bil_pkg::CH_NEWLINE);
            endcase
         end else begin
            repeat ($urandom_range(3, 1)) add_char(8'($urandom_range(255)));
         end

         // separator, sometimes none
         case ($urandom_range(9))
            0, 1, 2, 3: add_char(" ");
            4, 5: add_char(bil_pkg::CH_NEWLINE);
            6: add_char(8'h09);
            7: add_char(8'($urandom_range(255)));
            default: ;
         endcase

         // end of source on a byte of any sort
         if (sources_left != 0) begin
            sources_left--;
         end else begin
            case ($urandom_range(3))
               0: add_char(8'($urandom_range(255)), 1'b1);
               1: add_char(rand_word_char(), 1'b1);
               2: add_char(rand_bracket(), 1'b1);
               default: add_char(bil_pkg::CH_DOT, 1'b1);
            endcase
            sources_left = $urandom_range(30, 0);
         end
      end

      // position back at the start after end of source
      add_char(" ", 1'b1);
      add_text("(a)");
      total_items = source_items.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted != total_items || expected_tokens.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      kinds_seen = 0;
      for (int k = 0; k < 16; k++) kinds_seen += kind_hits[k];
      $display("covered %0d source bytes in %0d sources, %0d tokens, %0d bytes with two tokens",
               bytes_accepted, eos_seen, tokens_checked, double_steps);
      $display("token kinds seen %0d of 11, longest token %0d, output held off %0d cycles",
               kinds_seen, longest_token, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bil_pkg.sv
rtl/bil_ifs.sv
rtl/bil_scan_core.sv
rtl/bil_token_fifo.sv
rtl/bracket_ident_number_lexer.sv
tb/testbench.sv
